FILE: sv/fsci_pkg.sv
// Shared types, codes and sizes for the first-seen code indexer.
package fsci_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int CODE_W      = 16;

  localparam logic [1:0] MODE_CLASSIFY = 2'd0;
  localparam logic [1:0] MODE_CLEAR    = 2'd1;
  localparam logic [1:0] MODE_READ     = 2'd2;

  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_INSERTED  = 3'd1;
  localparam logic [2:0] ST_MALFORMED = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_PAST_END  = 3'd4;
  localparam logic [2:0] ST_CLEARED   = 3'd5;

  typedef struct packed {
    logic [1:0]        mode;
    logic [CODE_W-1:0] code;
    logic              bad_message;
    logic [IDX_W-1:0]  read_index;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [IDX_W-1:0]  index;
    logic [CODE_W-1:0] stored_code;
    logic [CNT_W-1:0]  entry_count;
  } rsp_t;

  // Search token that walks the row of cells, one cell per cycle.
  typedef struct packed {
    logic              valid;
    logic              is_read;
    logic [CODE_W-1:0] key;
    logic [IDX_W-1:0]  ridx;
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic [CODE_W-1:0] stored;
    logic              inserted;
  } tok_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_WALK,
    FSM_HOLD
  } fsm_t;

endpackage

FILE: sv/first_seen_code_indexer.sv
// Top level of the first-seen code indexer: control, entry count, result beat.
//
// Usage:
//   A request beat (req) moves when req_valid is high and req_stall is low;
//   a response beat (rsp) moves when rsp_valid is high and rsp_stall is low.
//   Every request gives exactly one response, in order.
//   Classify and read requests send a search token down a row of
//   TABLE_DEPTH cells, one cell per cycle; the result then passes through
//   the pending result register and the output register before a
//   response beat is on offer.
//   Malformed, clear and unknown-mode requests skip the walk; their result
//   is built at acceptance and passes through the same two registers.
//   Only one request is in flight; req_stall is high while it is worked on.
//   A finished response waits in the output register while rsp_stall is
//   high; the next request is already accepted and walks meanwhile, and
//   its result holds until the output register frees up.
//   Reset empties the table (entry count zero); entries themselves are not
//   cleared, since only entries below the count are ever compared or read.
module first_seen_code_indexer
  import fsci_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  fsm_t             state;
  fsm_t             state_next;
  logic [CNT_W-1:0] count;
  rsp_t             res;
  rsp_t             res_next;
  tok_t             launch;
  tok_t             done_tok;
  logic             accept;
  logic             needs_walk;
  logic             out_free;
  logic             load_out;

  assign accept     = req_valid && !req_stall;
  assign needs_walk = ((req.mode == MODE_CLASSIFY) && !req.bad_message) ||
                      (req.mode == MODE_READ);
  assign out_free   = !rsp_valid || !rsp_stall;

  // launch the token straight into the first cell
  always_comb begin
    launch          = '0;
    launch.valid    = accept && needs_walk;
    launch.is_read  = (req.mode == MODE_READ);
    launch.key      = req.code;
    launch.ridx     = req.read_index;
  end

  fsci_chain u_chain (
    .clk     (clk),
    .rst     (rst),
    .count   (count),
    .tok_in  (launch),
    .tok_out (done_tok)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      FSM_IDLE: begin
        if (accept) begin
          state_next = needs_walk ? FSM_WALK : FSM_HOLD;
        end
      end
      FSM_WALK: begin
        if (done_tok.valid) begin
          state_next = FSM_HOLD;
        end
      end
      FSM_HOLD: begin
        if (out_free) begin
          state_next = FSM_IDLE;
        end
      end
      default: state_next = FSM_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    req_stall = 1'b1;
    load_out  = 1'b0;
    unique case (state)
      FSM_IDLE: req_stall = 1'b0;
      FSM_WALK: req_stall = 1'b1;
      FSM_HOLD: load_out  = out_free;
      default:  req_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // entry count: drop to zero on clear, advance on insert
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept && (req.mode == MODE_CLEAR)) begin
      count <= '0;
    end else if (state == FSM_WALK && done_tok.valid && done_tok.inserted) begin
      count <= count + CNT_W'(1);
    end
  end

  // pending result: built at acceptance for direct cases, at walk end otherwise
  always_comb begin
    res_next = res;
    if (accept && !needs_walk) begin
      res_next.index       = '0;
      res_next.stored_code = '0;
      res_next.entry_count = count;
      priority if (req.mode == MODE_CLASSIFY) begin
        res_next.status = ST_MALFORMED;
      end else if (req.mode == MODE_CLEAR) begin
        res_next.status      = ST_CLEARED;
        res_next.entry_count = '0;
      end else begin
        res_next.status = ST_PAST_END;
      end
    end else if (state == FSM_WALK && done_tok.valid) begin
      res_next.index       = '0;
      res_next.stored_code = '0;
      res_next.entry_count = count;
      if (done_tok.is_read) begin
        if (done_tok.hit) begin
          res_next.status      = ST_FOUND;
          res_next.index       = done_tok.ridx;
          res_next.stored_code = done_tok.stored;
        end else begin
          res_next.status = ST_PAST_END;
        end
      end else begin
        priority if (done_tok.hit) begin
          res_next.status = ST_FOUND;
          res_next.index  = done_tok.hit_idx;
        end else if (done_tok.inserted) begin
          res_next.status      = ST_INSERTED;
          res_next.index       = count[IDX_W-1:0];
          res_next.entry_count = count + CNT_W'(1);
        end else begin
          res_next.status = ST_FULL;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  // output register: hold while stalled, load when free
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_out) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (load_out) begin
      rsp <= res;
    end
  end

endmodule

FILE: sv/fsci_cell.sv
// One table entry: compare, read or fill as the search token passes through.
module fsci_cell
  import fsci_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] cell_id,
  input  logic [CNT_W-1:0] count,
  input  tok_t             tok_in,
  output tok_t             tok_out
);

  logic [CODE_W-1:0] entry;
  logic              in_use;
  logic              match;
  logic              rd;
  logic              wr;
  tok_t              tok_next;

  assign in_use = {1'b0, cell_id} < count;
  assign match  = tok_in.valid && !tok_in.is_read && !tok_in.hit && in_use &&
                  (entry == tok_in.key);
  assign rd     = tok_in.valid && tok_in.is_read && in_use && (cell_id == tok_in.ridx);
  // the free entry sees a final hit flag: every entry in use lies before it
  assign wr     = tok_in.valid && !tok_in.is_read && !tok_in.hit &&
                  ({1'b0, cell_id} == count);

  always_comb begin
    tok_next = tok_in;
    if (match) begin
      tok_next.hit     = 1'b1;
      tok_next.hit_idx = cell_id;
    end
    if (rd) begin
      tok_next.hit    = 1'b1;
      tok_next.stored = entry;
    end
    if (wr) begin
      tok_next.inserted = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_next.valid;
    end
    tok_out.is_read  <= tok_next.is_read;
    tok_out.key      <= tok_next.key;
    tok_out.ridx     <= tok_next.ridx;
    tok_out.hit      <= tok_next.hit;
    tok_out.hit_idx  <= tok_next.hit_idx;
    tok_out.stored   <= tok_next.stored;
    tok_out.inserted <= tok_next.inserted;
    if (wr) begin
      entry <= tok_in.key;
    end
  end

endmodule

FILE: sv/fsci_chain.sv
// Row of table cells; the search token hops one cell per cycle.
module fsci_chain
  import fsci_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [CNT_W-1:0] count,
  input  tok_t             tok_in,
  output tok_t             tok_out
);

  tok_t link [TABLE_DEPTH+1];

  assign link[0] = tok_in;
  assign tok_out = link[TABLE_DEPTH];

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    fsci_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cell_id (IDX_W'(g)),
      .count   (count),
      .tok_in  (link[g]),
      .tok_out (link[g+1])
    );
  end

endmodule

FILE: test/tb_first_seen_code_indexer.sv
// Testbench for the first-seen code indexer: directed table, random beats, scoreboard.
`timescale 1ns / 1ps

module tb_first_seen_code_indexer;
  import fsci_pkg::*;

  // Mode three has no name in the package; the block answers it with past_end.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int POOL_SIZE       = 20;
  localparam int RANDOM_BEATS    = 1500;
  localparam int CHUNKS          = 8;
  localparam int IDLE_LIMIT      = 5000;
  // Drain time after the last response: a couple of full walks.
  localparam int DRAIN_CYCLES    = 2 * (TABLE_DEPTH + 2);

  // One row of the directed table; typed rows carry their own expected response.
  typedef struct packed {
    req_t beat;
    bit   typed;
    rsp_t want;
  } row_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  // Shadow of the block's table and fill level.
  logic [CODE_W-1:0] code_store [TABLE_DEPTH];
  int                codes_in_use;

  logic [CODE_W-1:0] code_pool [POOL_SIZE];
  rsp_t              outcomes_due [$];
  row_t              steps [$];

  int send_idle_pct;
  int stall_pct;
  int mismatches;
  int idle_cycles;

  first_seen_code_indexer u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Work out the response to one accepted request beat and advance the shadow state.
  function automatic rsp_t index_outcome(input req_t b);
    rsp_t             o;
    bit               hit;
    logic [IDX_W-1:0] hit_idx;
    o       = '0;
    hit     = 1'b0;
    hit_idx = '0;
    case (b.mode)
      MODE_CLASSIFY: begin
        if (b.bad_message) begin
          // Malformed message: no lookup at all.
          o.status = ST_MALFORMED;
        end else begin
          // First (lowest) match wins.
          for (int i = 0; i < codes_in_use; i++) begin
            if (!hit && code_store[i] == b.code) begin
              hit     = 1'b1;
              hit_idx = IDX_W'(i);
            end
          end
          if (hit) begin
            o.status = ST_FOUND;
            o.index  = hit_idx;
          end else if (codes_in_use >= TABLE_DEPTH) begin
            // Full table: refuse the new code, write nothing.
            o.status = ST_FULL;
          end else begin
            code_store[codes_in_use] = b.code;
            o.status = ST_INSERTED;
            o.index  = IDX_W'(codes_in_use);
            codes_in_use++;
          end
        end
      end
      MODE_CLEAR: begin
        // Entries keep their bits; they just drop out of use.
        codes_in_use = 0;
        o.status     = ST_CLEARED;
      end
      MODE_READ: begin
        if (b.read_index < codes_in_use) begin
          o.status      = ST_FOUND;
          o.index       = b.read_index;
          o.stored_code = code_store[b.read_index];
        end else begin
          o.status = ST_PAST_END;
        end
      end
      default: begin
        o.status = ST_PAST_END;
      end
    endcase
    o.entry_count = CNT_W'(codes_in_use);
    return o;
  endfunction

  function automatic void add_row(input logic [1:0] m, input logic [CODE_W-1:0] c,
                                  input logic bad, input logic [IDX_W-1:0] ri,
                                  input bit typed, input logic [2:0] st,
                                  input logic [IDX_W-1:0] ix,
                                  input logic [CODE_W-1:0] sc,
                                  input logic [CNT_W-1:0] cnt);
    row_t r;
    r.beat.mode        = m;
    r.beat.code        = c;
    r.beat.bad_message = bad;
    r.beat.read_index  = ri;
    r.typed            = typed;
    r.want.status      = st;
    r.want.index       = ix;
    r.want.stored_code = sc;
    r.want.entry_count = cnt;
    steps.push_back(r);
  endfunction

  // Random beat, mostly classify traffic over a small pool so codes repeat
  // and the table fills up between the occasional clears.
  function automatic req_t random_beat();
    req_t b;
    int   pick;
    b.mode        = MODE_CLASSIFY;
    b.code        = CODE_W'($urandom);
    b.bad_message = 1'b0;
    b.read_index  = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
    pick          = $urandom_range(0, 99);
    if (pick < 3) begin
      b.mode        = MODE_CLEAR;
      b.bad_message = 1'($urandom_range(0, 1));
    end else if (pick < 16) begin
      b.mode        = MODE_READ;
      b.bad_message = 1'($urandom_range(0, 1));
    end else if (pick < 18) begin
      b.mode        = MODE_UNUSED;
      b.bad_message = 1'($urandom_range(0, 1));
    end else begin
      if (pick < 23) b.bad_message = 1'b1;
      if ($urandom_range(0, 99) < 75) b.code = code_pool[$urandom_range(0, POOL_SIZE - 1)];
    end
    return b;
  endfunction

  // Offer one request beat, hold it until accepted, then queue its response.
  task automatic send_beat(input req_t b, input bit typed, input rsp_t want);
    rsp_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= b;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = index_outcome(b);
    outcomes_due.push_back(typed ? want : predicted);
  endtask

  initial begin : stimulus
    rst           <= 1'b1;
    req_valid     <= 1'b0;
    req           <= '0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    mismatches     = 0;
    codes_in_use   = 0;

    // Directed table: reset state, extremes, every mode, every status.
    add_row(MODE_READ,     16'h0000, 1'b0, 4'd0,  1'b1, ST_PAST_END,  4'd0, 16'h0000, 5'd0);
    add_row(MODE_CLASSIFY, 16'h0000, 1'b0, 4'd0,  1'b1, ST_INSERTED,  4'd0, 16'h0000, 5'd1);
    add_row(MODE_CLASSIFY, 16'hFFFF, 1'b0, 4'd15, 1'b1, ST_INSERTED,  4'd1, 16'h0000, 5'd2);
    add_row(MODE_CLASSIFY, 16'h0000, 1'b0, 4'd0,  1'b1, ST_FOUND,     4'd0, 16'h0000, 5'd2);
    add_row(MODE_CLASSIFY, 16'hFFFF, 1'b1, 4'd0,  1'b1, ST_MALFORMED, 4'd0, 16'h0000, 5'd2);
    add_row(MODE_READ,     16'h0000, 1'b0, 4'd1,  1'b1, ST_FOUND,     4'd1, 16'hFFFF, 5'd2);
    add_row(MODE_READ,     16'hFFFF, 1'b1, 4'd15, 1'b1, ST_PAST_END,  4'd0, 16'h0000, 5'd2);
    add_row(MODE_UNUSED,   16'hFFFF, 1'b1, 4'd15, 1'b1, ST_PAST_END,  4'd0, 16'h0000, 5'd2);
    // Walk a single one down the code to fill the rest of the table.
    for (int k = 0; k < TABLE_DEPTH - 2; k++) begin
      add_row(MODE_CLASSIFY, 16'h8000 >> k, 1'b0, 4'd0, 1'b0, ST_FOUND, 4'd0, 16'h0000, 5'd0);
    end
    add_row(MODE_CLASSIFY, 16'h1234, 1'b0, 4'd0,  1'b1, ST_FULL,      4'd0, 16'h0000, 5'd16);
    add_row(MODE_CLASSIFY, 16'hFFFF, 1'b0, 4'd0,  1'b0, ST_FOUND,     4'd0, 16'h0000, 5'd0);
    add_row(MODE_READ,     16'h0000, 1'b0, 4'd15, 1'b0, ST_FOUND,     4'd0, 16'h0000, 5'd0);
    add_row(MODE_CLEAR,    16'hFFFF, 1'b1, 4'd15, 1'b1, ST_CLEARED,   4'd0, 16'h0000, 5'd0);
    add_row(MODE_READ,     16'h0000, 1'b0, 4'd0,  1'b1, ST_PAST_END,  4'd0, 16'h0000, 5'd0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < steps.size(); r++) begin
      send_beat(steps[r].beat, steps[r].typed, steps[r].want);
    end

    // Random part: rotate through the idling phases twice.
    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      case (chunk % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 73; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 73; end
        default: begin send_idle_pct = 15; stall_pct = 15; end
      endcase
      for (int p = 0; p < POOL_SIZE; p++) code_pool[p] = CODE_W'($urandom);
      for (int n = 0; n < RANDOM_BEATS / CHUNKS; n++) begin
        send_beat(random_beat(), 1'b0, '0);
      end
    end

    // Drop valid, drain the response queue, then watch for stray beats.
    req_valid <= 1'b0;
    stall_pct  = 0;
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Response side: check each accepted beat against the oldest expectation,
  // then pick the stall for the next cycle.
  rsp_t want_rsp;

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (outcomes_due.size() == 0) begin
          $display("%0t: response beat with nothing expected: %p", $time, rsp);
          mismatches++;
        end else begin
          want_rsp = outcomes_due.pop_front();
          if (rsp.status !== want_rsp.status) begin
            $display("%0t: status expected %0d got %0d", $time, want_rsp.status, rsp.status);
            mismatches++;
          end
          if (rsp.index !== want_rsp.index) begin
            $display("%0t: index expected %0d got %0d", $time, want_rsp.index, rsp.index);
            mismatches++;
          end
          if (rsp.stored_code !== want_rsp.stored_code) begin
            $display("%0t: stored_code expected %h got %h", $time, want_rsp.stored_code,
                     rsp.stored_code);
            mismatches++;
          end
          if (rsp.entry_count !== want_rsp.entry_count) begin
            $display("%0t: entry_count expected %0d got %0d", $time, want_rsp.entry_count,
                     rsp.entry_count);
            mismatches++;
          end
        end
      end
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Watchdog: too long without a beat on either channel ends the run.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
